// ----- rtl/ssa_pkg.sv -----
// shared constants, defaults and size class helpers for the slab slice allocator
`default_nettype none
package ssa_pkg;
    localparam int DEF_NUM_BLOCKS      = 16;
    localparam int DEF_PAGES_PER_BLOCK = 16;
    localparam int DEF_GROW_STEP       = 8;

    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_WORDS  = 4;
    localparam int WORD_BITS   = 64;
    localparam int NUM_CLASSES = 9;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    localparam logic [1:0] HINT_NONE    = 2'd0;
    localparam logic [1:0] HINT_RECYCLE = 2'd1;
    localparam logic [1:0] HINT_SEQ     = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // smallest class k with 16 << (k-1) >= req, zero maps to class 1
    function automatic logic [3:0] size_class(input logic [15:0] req);
        logic [3:0] k;
        k = 4'(NUM_CLASSES);
        for (int i = NUM_CLASSES; i >= 1; i--) begin
            if (17'(16 << (i - 1)) >= {1'b0, req}) begin
                k = 4'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [8:0] class_count(input logic [3:0] k);
        return 9'(256 >> (k - 4'd1));
    endfunction

    function automatic logic [12:0] class_bytes(input logic [3:0] k);
        return 13'(16 << (k - 4'd1));
    endfunction
endpackage
`default_nettype wire

// ----- rtl/slab_slice_allocator.sv -----
// slab slice allocator: top level with sequencer, bitmap memory and block state
`default_nettype none
// One transaction at a time: start is taken when busy is low, and exactly one
// result appears on the o_ ports for a single cycle with o_valid; the receiver
// cannot stall it and must capture it then. After reset the block clears its
// page bitmaps and page full marks with busy high. A free reads the bitmap word
// and writes it back with the slice bit cleared. An allocate visits blocks in
// order, tries the block's hint first, then scans its pages and up to 4 bitmap
// words per page (one 64-bit word per cycle through the single read port of
// the bitmap memory), and grows the pool when no active block can serve it.
module slab_slice_allocator import ssa_pkg::*; #(
    parameter int NUM_BLOCKS      = DEF_NUM_BLOCKS,
    parameter int PAGES_PER_BLOCK = DEF_PAGES_PER_BLOCK,
    parameter int GROW_STEP       = DEF_GROW_STEP
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [15:0] i_request_size,
    input  wire logic [3:0]  i_free_block,
    input  wire logic [3:0]  i_free_page,
    input  wire logic [7:0]  i_free_slice,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [3:0]       o_grant_block,
    output logic [3:0]       o_grant_page,
    output logic [7:0]       o_grant_slice,
    output logic [12:0]      o_grant_size
);
    localparam int NP   = NUM_BLOCKS * PAGES_PER_BLOCK;
    localparam int NPW  = NP > 1 ? $clog2(NP) : 1;
    localparam int WAW  = NPW + 2;
    localparam int NW   = NP * PAGE_WORDS;
    localparam int BW   = NUM_BLOCKS > 1 ? $clog2(NUM_BLOCKS) : 1;
    localparam int AW   = $clog2(NUM_BLOCKS + 1);
    localparam int PGW  = PAGES_PER_BLOCK > 1 ? $clog2(PAGES_PER_BLOCK) : 1;
    localparam int PCW  = $clog2(PAGES_PER_BLOCK + 1);
    localparam int INIT_ACT = GROW_STEP < NUM_BLOCKS ? GROW_STEP : NUM_BLOCKS;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FREE_RD, S_FREE_WR, S_BLK, S_HINT_WR, S_SEQ_CHK, S_PG, S_WD
    } t_state;

    t_state r_state;

    logic [WORD_BITS-1:0] mem_words [NW];
    logic                 mem_pfull [NP];
    logic [WORD_BITS-1:0] r_wrd;
    logic                 r_pfd;

    logic           r_bfull  [NUM_BLOCKS];
    logic [3:0]     r_bclass [NUM_BLOCKS];
    logic [1:0]     r_hkind  [NUM_BLOCKS];
    logic [PGW-1:0] r_hpage  [NUM_BLOCKS];
    logic [7:0]     r_hslice [NUM_BLOCKS];

    logic [AW-1:0]  r_active;
    logic [AW-1:0]  r_blk;
    logic [PCW-1:0] r_pg;
    logic [1:0]     r_w;
    logic           r_first;
    logic [3:0]     r_k;
    logic [WAW-1:0] r_clr;
    logic [NPW-1:0] r_fpa;
    logic [BW-1:0]  r_fb;
    logic [PGW-1:0] r_fp;
    logic [7:0]     r_fs;

    logic           r_valid;
    logic [1:0]     r_status;
    logic [3:0]     r_gblock;
    logic [3:0]     r_gpage;
    logic [7:0]     r_gslice;
    logic [12:0]    r_gsize;

    logic [BW-1:0]        blk;
    logic [8:0]           count;
    logic [NPW-1:0]       hint_pa;
    logic [NPW-1:0]       scan_pa;
    logic [8:0]           nx;
    logic [WORD_BITS-1:0] vmask;
    logic [WORD_BITS-1:0] masked;
    logic                 found;
    logic [5:0]           idx;
    logic [7:0]           scan_s;
    logic [2:0]           nwords;
    logic                 last_word;
    logic                 skip_page;
    logic [WAW-1:0]       w_ra;
    logic                 w_we;
    logic [WAW-1:0]       w_wa;
    logic [WORD_BITS-1:0] w_wd;
    logic [NPW-1:0]       pf_ra;
    logic                 pf_we;
    logic [NPW-1:0]       pf_wa;
    logic                 pf_wd;
    logic [AW+8:0]        grow_sum;

    always_comb begin
        blk     = r_blk[BW-1:0];
        count   = class_count(r_k);
        hint_pa = NPW'(int'(blk) * PAGES_PER_BLOCK + int'(r_hpage[blk]));
        scan_pa = NPW'(int'(blk) * PAGES_PER_BLOCK + int'(r_pg));
        nx      = {1'b0, r_hslice[blk]} + 9'd1;
        vmask   = (count >= 9'd64) ? '1 : ((WORD_BITS'(1) << count[5:0]) - WORD_BITS'(1));
        masked  = r_wrd | ~vmask;
        found   = ~&masked;
        idx     = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!masked[i]) begin
                idx = 6'(i);
            end
        end
        scan_s    = {r_w, idx};
        nwords    = (count >= 9'd64) ? count[8:6] : 3'd1;
        last_word = ({1'b0, r_w} + 3'd1) == nwords;
        skip_page = r_first && r_pfd;
        grow_sum  = (AW + 9)'(int'(r_active) + GROW_STEP);
    end

    // memory port control
    always_comb begin
        w_ra  = '0;
        w_we  = 1'b0;
        w_wa  = '0;
        w_wd  = '0;
        pf_ra = scan_pa;
        pf_we = 1'b0;
        pf_wa = '0;
        pf_wd = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                w_wa  = r_clr;
                pf_we = 1'b1;
                pf_wa = r_clr[WAW-1:2];
            end
            S_FREE_RD: begin
                w_ra = {r_fpa, r_fs[7:6]};
            end
            S_FREE_WR: begin
                w_we  = 1'b1;
                w_wa  = {r_fpa, r_fs[7:6]};
                w_wd  = r_wrd & ~(WORD_BITS'(1) << r_fs[5:0]);
                pf_we = 1'b1;
                pf_wa = r_fpa;
            end
            S_BLK: begin
                if (r_hkind[blk] == HINT_RECYCLE) begin
                    w_ra = {hint_pa, r_hslice[blk][7:6]};
                end else begin
                    w_ra = {hint_pa, nx[7:6]};
                end
            end
            S_HINT_WR: begin
                w_we = 1'b1;
                w_wa = {hint_pa, r_hslice[blk][7:6]};
                w_wd = r_wrd | (WORD_BITS'(1) << r_hslice[blk][5:0]);
            end
            S_SEQ_CHK: begin
                w_we = !r_wrd[nx[5:0]];
                w_wa = {hint_pa, nx[7:6]};
                w_wd = r_wrd | (WORD_BITS'(1) << nx[5:0]);
            end
            S_PG: begin
                w_ra = {scan_pa, 2'd0};
            end
            S_WD: begin
                w_ra = {scan_pa, r_w + 2'd1};
                if (!skip_page) begin
                    if (found) begin
                        w_we  = 1'b1;
                        w_wa  = {scan_pa, r_w};
                        w_wd  = r_wrd | (WORD_BITS'(1) << idx);
                        pf_we = ({1'b0, scan_s} == count - 9'd1);
                    end else begin
                        pf_we = last_word;
                    end
                    pf_wa = scan_pa;
                    pf_wd = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_words[w_wa] <= w_wd;
        end
        r_wrd <= mem_words[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pf_we) begin
            mem_pfull[pf_wa] <= pf_wd;
        end
        r_pfd <= mem_pfull[pf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_valid  <= 1'b0;
            r_active <= AW'(INIT_ACT);
            for (int b = 0; b < NUM_BLOCKS; b++) begin
                r_bfull[b]  <= 1'b0;
                r_bclass[b] <= '0;
                r_hkind[b]  <= HINT_NONE;
                r_hpage[b]  <= '0;
                r_hslice[b] <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + WAW'(1);
                    if (int'(r_clr) == NW - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_status <= ST_DONE;
                        r_gblock <= '0;
                        r_gpage  <= '0;
                        r_gslice <= '0;
                        r_gsize  <= '0;
                        r_k      <= size_class(i_request_size);
                        r_blk    <= '0;
                        r_fb     <= BW'(i_free_block);
                        r_fp     <= PGW'(i_free_page);
                        r_fs     <= i_free_slice;
                        r_fpa    <= NPW'(int'(i_free_block) * PAGES_PER_BLOCK
                                         + int'(i_free_page));
                        if (i_command == CMD_FREE) begin
                            if (int'(i_free_block) < NUM_BLOCKS
                                    && int'(i_free_page) < PAGES_PER_BLOCK) begin
                                r_state <= S_FREE_RD;
                            end else begin
                                r_valid <= 1'b1;
                            end
                        end else if (int'(i_request_size) > PAGE_BYTES) begin
                            r_status <= ST_TOO_LARGE;
                            r_valid  <= 1'b1;
                        end else begin
                            r_state <= S_BLK;
                        end
                    end
                end
                S_FREE_RD: begin
                    r_state <= S_FREE_WR;
                end
                S_FREE_WR: begin
                    r_bfull[r_fb]  <= 1'b0;
                    r_hkind[r_fb]  <= HINT_RECYCLE;
                    r_hpage[r_fb]  <= r_fp;
                    r_hslice[r_fb] <= r_fs;
                    r_valid        <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_BLK: begin
                    if (r_blk >= r_active) begin
                        if (int'(r_active) < NUM_BLOCKS) begin
                            r_active <= (int'(grow_sum) > NUM_BLOCKS)
                                        ? AW'(NUM_BLOCKS) : AW'(grow_sum);
                            r_blk    <= '0;
                        end else begin
                            r_status <= ST_EXHAUSTED;
                            r_valid  <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else if (r_bfull[blk]
                            || (r_bclass[blk] != '0 && r_bclass[blk] != r_k)) begin
                        r_blk <= r_blk + AW'(1);
                    end else begin
                        r_bclass[blk] <= r_k;
                        r_pg          <= '0;
                        if (r_hkind[blk] == HINT_RECYCLE) begin
                            r_state <= S_HINT_WR;
                        end else if (r_hkind[blk] == HINT_SEQ && nx < count) begin
                            r_state <= S_SEQ_CHK;
                        end else begin
                            r_state <= S_PG;
                        end
                    end
                end
                S_HINT_WR: begin
                    r_hkind[blk] <= HINT_NONE;
                    r_gblock     <= 4'(blk);
                    r_gpage      <= 4'(r_hpage[blk]);
                    r_gslice     <= r_hslice[blk];
                    r_gsize      <= class_bytes(r_k);
                    r_valid      <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_SEQ_CHK: begin
                    if (!r_wrd[nx[5:0]]) begin
                        r_hslice[blk] <= nx[7:0];
                        r_gblock      <= 4'(blk);
                        r_gpage       <= 4'(r_hpage[blk]);
                        r_gslice      <= nx[7:0];
                        r_gsize       <= class_bytes(r_k);
                        r_valid       <= 1'b1;
                        r_state       <= S_IDLE;
                    end else begin
                        r_state <= S_PG;
                    end
                end
                S_PG: begin
                    if (int'(r_pg) == PAGES_PER_BLOCK) begin
                        r_bfull[blk] <= 1'b1;
                        r_blk        <= r_blk + AW'(1);
                        r_state      <= S_BLK;
                    end else begin
                        r_w     <= '0;
                        r_first <= 1'b1;
                        r_state <= S_WD;
                    end
                end
                S_WD: begin
                    r_first <= 1'b0;
                    if (skip_page) begin
                        r_pg    <= r_pg + PCW'(1);
                        r_state <= S_PG;
                    end else if (found) begin
                        // a grant of the page's last slice leaves the hint alone
                        if ({1'b0, scan_s} != count - 9'd1) begin
                            r_hkind[blk]  <= HINT_SEQ;
                            r_hpage[blk]  <= PGW'(r_pg);
                            r_hslice[blk] <= scan_s;
                        end
                        r_gblock <= 4'(blk);
                        r_gpage  <= 4'(r_pg);
                        r_gslice <= scan_s;
                        r_gsize  <= class_bytes(r_k);
                        r_valid  <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (last_word) begin
                        r_pg    <= r_pg + PCW'(1);
                        r_state <= S_PG;
                    end else begin
                        r_w <= r_w + 2'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_grant_block = r_gblock;
    assign o_grant_page  = r_gpage;
    assign o_grant_slice = r_gslice;
    assign o_grant_size  = r_gsize;
endmodule
`default_nettype wire

// ----- verif/ssa_checker.sv -----
// allocation predictor and result checker for the slab slice allocator
`timescale 1ns / 1ps
module ssa_checker import ssa_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        i_command,
    input  wire logic [15:0] i_request_size,
    input  wire logic [3:0]  i_free_block,
    input  wire logic [3:0]  i_free_page,
    input  wire logic [7:0]  i_free_slice,
    input  wire logic        o_valid,
    input  wire logic [1:0]  o_status,
    input  wire logic [3:0]  o_grant_block,
    input  wire logic [3:0]  o_grant_page,
    input  wire logic [7:0]  o_grant_slice,
    input  wire logic [12:0] o_grant_size,
    output int               o_fail_count,
    output int               o_pending
);
    localparam int NBLK = DEF_NUM_BLOCKS;
    localparam int NPG  = DEF_PAGES_PER_BLOCK;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  blk;
        logic [3:0]  page;
        logic [7:0]  slice;
        logic [12:0] size;
    } t_grant;

    logic [255:0] used_map [NBLK*NPG];
    logic         page_full [NBLK*NPG];
    logic         block_full [NBLK];
    logic [3:0]   block_cls [NBLK];
    logic [1:0]   hint_kind [NBLK];
    logic [3:0]   hint_pg [NBLK];
    logic [7:0]   hint_sl [NBLK];
    int           active_cnt;
    t_grant       expected_grants [$];
    int           fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_grants.size();

    function automatic t_grant predict_alloc(input logic [15:0] req);
        t_grant r;
        int k, cnt, pg;
        logic [8:0] nx;
        r = '0;
        if (req > 16'(PAGE_BYTES)) begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        k = 1;
        while ((16 << (k - 1)) < req) k++;
        cnt = PAGE_BYTES >> (k + 3);
        forever begin
            for (int i = 0; i < active_cnt; i++) begin
                if (block_full[i]) continue;
                if (block_cls[i] != 0 && block_cls[i] != 4'(k)) continue;
                block_cls[i] = 4'(k);
                r.status = ST_DONE;
                r.blk    = 4'(i);
                r.size   = 13'(16 << (k - 1));
                if (hint_kind[i] == HINT_RECYCLE) begin
                    used_map[i*NPG + hint_pg[i]][hint_sl[i]] = 1'b1;
                    hint_kind[i] = HINT_NONE;
                    r.page  = hint_pg[i];
                    r.slice = hint_sl[i];
                    return r;
                end else if (hint_kind[i] == HINT_SEQ) begin
                    nx = {1'b0, hint_sl[i]} + 9'd1;
                    if (nx < cnt && !used_map[i*NPG + hint_pg[i]][nx[7:0]]) begin
                        used_map[i*NPG + hint_pg[i]][nx[7:0]] = 1'b1;
                        hint_sl[i] = nx[7:0];
                        r.page  = hint_pg[i];
                        r.slice = nx[7:0];
                        return r;
                    end
                end
                for (int j = 0; j < NPG; j++) begin
                    pg = i*NPG + j;
                    if (page_full[pg]) continue;
                    for (int s = 0; s < cnt; s++) begin
                        if (!used_map[pg][s]) begin
                            used_map[pg][s] = 1'b1;
                            if (s == cnt - 1) begin
                                page_full[pg] = 1'b1;
                            end else begin
                                hint_kind[i] = HINT_SEQ;
                                hint_pg[i]   = 4'(j);
                                hint_sl[i]   = 8'(s);
                            end
                            r.page  = 4'(j);
                            r.slice = 8'(s);
                            return r;
                        end
                    end
                    page_full[pg] = 1'b1;
                end
                block_full[i] = 1'b1;
            end
            if (active_cnt < NBLK) begin
                active_cnt = (active_cnt + DEF_GROW_STEP > NBLK) ? NBLK
                           : active_cnt + DEF_GROW_STEP;
            end else begin
                r = '0;
                r.status = ST_EXHAUSTED;
                return r;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_grant g, e;
        if (!i_rst_n) begin
            for (int p = 0; p < NBLK*NPG; p++) begin
                used_map[p]  = '0;
                page_full[p] = 1'b0;
            end
            for (int b = 0; b < NBLK; b++) begin
                block_full[b] = 1'b0;
                block_cls[b]  = '0;
                hint_kind[b]  = HINT_NONE;
                hint_pg[b]    = '0;
                hint_sl[b]    = '0;
            end
            active_cnt = (DEF_GROW_STEP < NBLK) ? DEF_GROW_STEP : NBLK;
            expected_grants.delete();
            fails = 0;
        end else begin
            if (start && !busy) begin
                if (i_command == CMD_FREE) begin
                    // all 4-bit block/page values are in range at default sizes
                    used_map[i_free_block*NPG + i_free_page][i_free_slice] = 1'b0;
                    block_full[i_free_block] = 1'b0;
                    page_full[i_free_block*NPG + i_free_page] = 1'b0;
                    hint_kind[i_free_block] = HINT_RECYCLE;
                    hint_pg[i_free_block]   = i_free_page;
                    hint_sl[i_free_block]   = i_free_slice;
                    expected_grants.push_back('0);
                end else begin
                    expected_grants.push_back(predict_alloc(i_request_size));
                end
            end
            if (o_valid) begin
                g = '{o_status, o_grant_block, o_grant_page, o_grant_slice, o_grant_size};
                if (expected_grants.size() == 0) begin
                    if (fails < 10) $display("unexpected result transaction: %p", g);
                    fails++;
                end else begin
                    e = expected_grants.pop_front();
                    if (g != e) begin
                        if (fails < 10)
                            $display({"mismatch: exp st=%0d b=%0d p=%0d s=%0d sz=%0d,",
                                      " got st=%0d b=%0d p=%0d s=%0d sz=%0d"},
                                     e.status, e.blk, e.page, e.slice, e.size,
                                     g.status, g.blk, g.page, g.slice, g.size);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

// ----- verif/testbench.sv -----
// stimulus and verdict for the slab slice allocator
`timescale 1ns / 1ps
module testbench;
    import ssa_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_command = CMD_ALLOC;
    logic [15:0] i_request_size = '0;
    logic [3:0]  i_free_block = '0;
    logic [3:0]  i_free_page = '0;
    logic [7:0]  i_free_slice = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [3:0]  o_grant_block, o_grant_page;
    logic [7:0]  o_grant_slice;
    logic [12:0] o_grant_size;
    int          fail_count, pending;
    logic [15:0] live_slices [$];
    int          burst_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    slab_slice_allocator dut (.*);

    ssa_checker u_chk (.*, .o_fail_count(fail_count), .o_pending(pending));

    // remember granted slices so most frees return real allocations
    always @(posedge i_clk) begin
        if (o_valid && o_status == ST_DONE && o_grant_size != 0)
            live_slices.push_back({o_grant_block, o_grant_page, o_grant_slice});
    end

    task automatic issue(input logic cmd, input logic [15:0] req, input logic [15:0] loc);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
            burst_left = $urandom_range(20, 1);
        end
        burst_left--;
        i_command      <= cmd;
        i_request_size <= req;
        {i_free_block, i_free_page, i_free_slice} <= loc;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic alloc(input logic [15:0] req);
        issue(CMD_ALLOC, req, 16'($urandom));
    endtask

    task automatic free_any();
        int idx;
        logic [15:0] loc;
        if (live_slices.size() > 0 && $urandom_range(9, 0) != 0) begin
            idx = $urandom_range(live_slices.size() - 1, 0);
            loc = live_slices[idx];
            live_slices.delete(idx);
        end else begin
            loc = 16'($urandom);
        end
        issue(CMD_FREE, 16'($urandom), loc);
    endtask

    function automatic logic [15:0] pick_size(input int mode);
        int k;
        k = $urandom_range(8, 0);
        case (mode)
            0: return 16'($urandom_range(16 << k, (16 << k) - (8 << k) + 1));
            1: return 16'($urandom_range(PAGE_BYTES, 0));
            2: return 16'($urandom_range(65535, PAGE_BYTES + 1));
            default: return 16'($urandom_range(PAGE_BYTES, 2049));
        endcase
    endfunction

    initial begin
        int mode;
        burst_left = 5;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: size corners, each class, too large, frees of odd slices
        alloc(16'd0);
        alloc(16'd1);
        alloc(16'd16);
        alloc(16'd17);
        alloc(16'd33);
        alloc(16'd100);
        alloc(16'd200);
        alloc(16'd500);
        alloc(16'd1000);
        alloc(16'd2048);
        alloc(16'd4096);
        alloc(16'd4097);
        alloc(16'hFFFF);
        issue(CMD_FREE, 16'h0, {4'd0, 4'd0, 8'd0});
        alloc(16'd16);
        alloc(16'd16);
        issue(CMD_FREE, 16'h0, {4'd1, 4'd0, 8'd255});
        alloc(16'd30);
        issue(CMD_FREE, 16'hFFFF, {4'd15, 4'd15, 8'd255});
        issue(CMD_FREE, 16'h0, {4'd9, 4'd3, 8'd77});
        alloc(16'd3000);
        alloc(16'd4096);

        // random: phases with mostly big sizes push toward exhaustion and growth
        for (int n = 0; n < 1000; n++) begin
            mode = (n % 250 < 120) ? 3 : $urandom_range(2, 0);
            if ($urandom_range(99, 0) < 30) free_any();
            else alloc(pick_size($urandom_range(9, 0) == 0 ? 2 : mode));
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("slab_slice_allocator test passed");
        end else begin
            $display("slab_slice_allocator test failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("slab_slice_allocator test failed");
        $finish;
    end
endmodule

// ----- slab_slice_allocator.f -----
rtl/ssa_pkg.sv
rtl/slab_slice_allocator.sv
verif/ssa_checker.sv
verif/testbench.sv
